@@ hw/rtl/brr2x_pkg.sv @@
// Shared constants for the binary 2x2 rank-order reduction block.
// Field widths, register indexes and rank codes; no dependencies.
package brr2x_pkg;

    localparam int PIX_W             = 32;  // source pixels per word
    localparam int HALF_W            = 16;  // reduced pixels per result
    localparam int LANES             = PIX_W / 2;
    localparam int IDX_W             = 8;   // halfword index width
    localparam int LEVEL_W           = 3;   // rank_level register width
    localparam int WIDTH_W           = 13;  // width_pixels register width
    localparam int CFG_ADDR_W        = 1;
    localparam int CFG_DATA_W        = 13;
    localparam int CNT_W             = 14;  // wide enough for any word count
    localparam int MAX_WORDS_DEFAULT = 128;

    localparam logic [LEVEL_W-1:0] RANK_LEVEL_RESET   = 3'd1;
    localparam logic [WIDTH_W-1:0] WIDTH_PIXELS_RESET = 13'd4096;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RANK_LEVEL   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH_PIXELS = 1'd1;

    // rank codes
    localparam logic [LEVEL_W-1:0] RANK_SUBSAMPLE = 3'd0;
    localparam logic [LEVEL_W-1:0] RANK_ONE       = 3'd1;
    localparam logic [LEVEL_W-1:0] RANK_TWO       = 3'd2;
    localparam logic [LEVEL_W-1:0] RANK_THREE     = 3'd3;

endpackage

@@ hw/rtl/brr2x_lane.sv @@
// One 2x2 cell evaluator: two pixels of the stored row and two of the new row.
// Depends on brr2x_pkg for rank codes and widths.
module brr2x_lane (
    input  logic [1:0]                    top_pair,   // [1] left, [0] right
    input  logic [1:0]                    bot_pair,
    input  logic [brr2x_pkg::LEVEL_W-1:0] rank_level,
    output logic                          cell_bit
);

    logic [2:0] on_count;

    assign on_count = 3'(top_pair[1]) + 3'(top_pair[0]) + 3'(bot_pair[1]) + 3'(bot_pair[0]);

    always_comb begin
        case (rank_level)
            brr2x_pkg::RANK_SUBSAMPLE: cell_bit = top_pair[1];
            brr2x_pkg::RANK_ONE:       cell_bit = (on_count >= 3'd1);
            brr2x_pkg::RANK_TWO:       cell_bit = (on_count >= 3'd2);
            brr2x_pkg::RANK_THREE:     cell_bit = (on_count >= 3'd3);
            default:                   cell_bit = (on_count == 3'd4);  // four and above
        endcase
    end

endmodule

@@ hw/rtl/brr2x_line_store.sv @@
// Line store holding the words of the last even source row.
// Single address, registered read; depends on brr2x_pkg for the word width.
module brr2x_line_store #(
    parameter int DEPTH = brr2x_pkg::MAX_WORDS_DEFAULT,
    parameter int AW    = 7
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic                        rd_en,
    input  logic [AW-1:0]               addr,
    input  logic [brr2x_pkg::PIX_W-1:0] wr_data,
    output logic [brr2x_pkg::PIX_W-1:0] rd_data
);

    logic [brr2x_pkg::PIX_W-1:0] mem [DEPTH];
    logic [brr2x_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/binary_rank_reduce_2x_top.sv @@
// Top level of the binary 2x2 rank-order reduction block.
// Depends on brr2x_pkg, brr2x_line_store and brr2x_lane.
//
// Usage:
//   Slave stream: s_tdata carries one 32-pixel source word (bit 31 leftmost),
//   s_tuser[0] flags the first word of a frame and restarts row and column.
//   Master stream: one transaction per word of an odd source row whose column
//   lies below the emitting word count; m_tdata holds the 16 reduced pixels
//   and the halfword index, m_tlast flags the last halfword of an output row.
//   Even-row words and surplus columns produce no transaction.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr (0 rank
//   level, 1 width in pixels); write only while the block is idle.
// Timing:
//   One word per cycle while the output is not stalled. A result passes from
//   its input transaction through the registered line-store read and read
//   stage, then through the sixteen cell lanes into the output register.
// Reset (aresetn low, synchronous) clears row and column position, empties
//   the pipeline and loads rank level 1 and width 4096. The line store is not
//   cleared; an odd row reads what the preceding even row wrote.
// Stall: while m_tready is low the output register holds, one more result
//   waits in the read stage, and s_tready drops only when both are full.
module binary_rank_reduce_2x_top #(
    parameter int MAX_WORDS_PER_ROW = brr2x_pkg::MAX_WORDS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // slave stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // [31:0] pixel_word
    input  logic [0:0]                       s_tuser,   // [0] frame_start
    // master stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // [15:0] out_bits, [23:16] halfword_index
    output logic                             m_tlast,   // row_end
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [brr2x_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [brr2x_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW     = (MAX_WORDS_PER_ROW > 1) ? $clog2(MAX_WORDS_PER_ROW) : 1;
    localparam int CNT_W  = brr2x_pkg::CNT_W;
    localparam int PIX_W  = brr2x_pkg::PIX_W;
    localparam int HALF_W = brr2x_pkg::HALF_W;
    localparam int IDX_W  = brr2x_pkg::IDX_W;
    localparam int WSH    = $clog2(PIX_W);

    // configuration registers
    logic [brr2x_pkg::LEVEL_W-1:0] rank_level_reg;
    logic [brr2x_pkg::WIDTH_W-1:0] width_pixels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_level_reg   <= brr2x_pkg::RANK_LEVEL_RESET;
            width_pixels_reg <= brr2x_pkg::WIDTH_PIXELS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                brr2x_pkg::REG_RANK_LEVEL:   rank_level_reg <= cfg_wdata[brr2x_pkg::LEVEL_W-1:0];
                brr2x_pkg::REG_WIDTH_PIXELS: width_pixels_reg <= cfg_wdata[brr2x_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // words per row and emitting words, derived from the width
    logic [CNT_W-1:0] wpr_raw;
    logic [CNT_W-1:0] wpr;
    logic [CNT_W-1:0] owr2;
    logic [CNT_W-1:0] emit;

    always_comb begin
        wpr_raw = (CNT_W'(width_pixels_reg) + CNT_W'(PIX_W - 1)) >> WSH;
        if (wpr_raw == '0) begin
            wpr = CNT_W'(1);
        end else if (wpr_raw > CNT_W'(MAX_WORDS_PER_ROW)) begin
            wpr = CNT_W'(MAX_WORDS_PER_ROW);
        end else begin
            wpr = wpr_raw;
        end
        owr2 = ((CNT_W'(width_pixels_reg >> 1) + CNT_W'(PIX_W - 1)) >> WSH) << 1;
        emit = (owr2 < wpr) ? owr2 : wpr;
    end

    // row and column tracking
    logic [CW-1:0]    column_count_reg;
    logic             odd_row_reg;
    logic [CW-1:0]    col_cur;
    logic             odd_cur;
    logic [CNT_W-1:0] col_ext;
    logic [CNT_W-1:0] col_p1;
    logic             row_wrap;
    logic             emit_hit;
    logic             s_accept;

    assign s_accept = s_tvalid && s_tready;
    assign col_cur  = s_tuser[0] ? '0 : column_count_reg;
    assign odd_cur  = s_tuser[0] ? 1'b0 : odd_row_reg;
    assign col_ext  = CNT_W'(col_cur);
    assign col_p1   = col_ext + CNT_W'(1);
    assign row_wrap = (col_p1 >= wpr);
    assign emit_hit = odd_cur && (col_ext < emit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            odd_row_reg      <= 1'b0;
        end else if (s_accept) begin
            column_count_reg <= row_wrap ? '0 : col_p1[CW-1:0];
            odd_row_reg      <= odd_cur ^ row_wrap;
        end
    end

    // line store: write on even rows, read on odd rows
    logic [PIX_W-1:0] top_word;

    brr2x_line_store #(
        .DEPTH (MAX_WORDS_PER_ROW),
        .AW    (CW)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s_accept && !odd_cur),
        .rd_en   (s_accept && odd_cur),
        .addr    (col_cur),
        .wr_data (s_tdata),
        .rd_data (top_word)
    );

    // read stage: bottom word and result tags, alongside the store read
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [PIX_W-1:0] s1_word_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_last_reg;
    logic             out_free;
    logic             out_load;
    logic             m_tvalid_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = emit_hit;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_word_reg <= s_tdata;
            s1_idx_reg  <= IDX_W'(col_cur);
            s1_last_reg <= (col_p1 == emit);
        end
    end

    // cell lanes, merged into one halfword, leftmost cell in the top bit
    logic [HALF_W-1:0] cell_bits;

    for (genvar k = 0; k < brr2x_pkg::LANES; k++) begin : g_lane
        brr2x_lane u_lane (
            .top_pair   (top_word[PIX_W-1-2*k -: 2]),
            .bot_pair   (s1_word_reg[PIX_W-1-2*k -: 2]),
            .rank_level (rank_level_reg),
            .cell_bit   (cell_bits[HALF_W-1-k])
        );
    end

    // output register
    logic                    m_tvalid_next;
    logic [HALF_W+IDX_W-1:0] m_tdata_reg;
    logic                    m_tlast_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {s1_idx_reg, cell_bits};
            m_tlast_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ hw/rtl/brr2x_checker.sv @@
// Port-level checker for binary_rank_reduce_2x_top, attached by bind.
// Depends only on the top level's ports.
module brr2x_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // with the output empty, the input never stalls
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a fresh result follows an input transaction through the read stage and the output register
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output without matching input transaction");

endmodule

bind binary_rank_reduce_2x_top brr2x_port_checker u_brr2x_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/brr2x_checker.sv @@
// Scoreboard for the binary 2x2 rank-order reduction block: snoops the
// configuration port and both streams, predicts each halfword, compares.
// Depends on brr2x_pkg for field widths and register indexes.
module brr2x_checker
    import brr2x_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,
    input  logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    pending,
    output int                    fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_WORDS_DEFAULT;
    localparam int FULL_CELL   = 4;   // all four pixels of a cell on
    localparam int PRINT_CAP   = 30;

    typedef struct packed {
        logic [HALF_W-1:0] bits;
        logic [IDX_W-1:0]  index;
        logic              row_end;
    } halfword_t;

    logic [PIX_W-1:0]   even_row_words [STORE_DEPTH];
    int unsigned        col_pos;
    bit                 on_odd_row;
    logic [LEVEL_W-1:0] rank_cfg;
    logic [WIDTH_W-1:0] width_cfg;
    halfword_t          halfword_q[$];
    int                 mismatches;

    function automatic int unsigned source_words(logic [WIDTH_W-1:0] w);
        int unsigned n;
        n = (w + 31) / 32;
        if (n < 1) n = 1;
        if (n > STORE_DEPTH) n = STORE_DEPTH;
        return n;
    endfunction

    // odd widths drop the unpaired last column
    function automatic int unsigned emitting_words(logic [WIDTH_W-1:0] w);
        int unsigned out_words;
        out_words = ((w / 2) + 31) / 32;
        return (2 * out_words < source_words(w)) ? 2 * out_words : source_words(w);
    endfunction

    // cell i covers source bits 2i+1 (left) and 2i of both rows
    function automatic logic [HALF_W-1:0] reduce_cells(logic [PIX_W-1:0] top,
                                                       logic [PIX_W-1:0] bot,
                                                       logic [LEVEL_W-1:0] level);
        logic [HALF_W-1:0] cells;
        int                on_count;
        int                need;
        need = (level > FULL_CELL) ? FULL_CELL : int'(level);
        for (int i = 0; i < HALF_W; i++) begin
            on_count = int'(top[2*i+1]) + int'(top[2*i]) + int'(bot[2*i+1]) + int'(bot[2*i]);
            cells[i] = (level == RANK_SUBSAMPLE) ? top[2*i+1] : (on_count >= need);
        end
        return cells;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        halfword_t        got;
        halfword_t        want;
        logic [PIX_W-1:0] word;
        int unsigned      wpr;
        int unsigned      emit;
        if (!aresetn) begin
            col_pos    = 0;
            on_odd_row = 1'b0;
            rank_cfg   = RANK_LEVEL_RESET;
            width_cfg  = WIDTH_PIXELS_RESET;
            mismatches = 0;
            halfword_q.delete();
            pending    <= 0;
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_RANK_LEVEL:   rank_cfg  = cfg_wdata[LEVEL_W-1:0];
                    REG_WIDTH_PIXELS: width_cfg = cfg_wdata[WIDTH_W-1:0];
                    default: ;
                endcase
            end

            // retire a result before taking a new word: latency keeps them apart
            if (m_tvalid && m_tready) begin
                got.bits    = m_tdata[HALF_W-1:0];
                got.index   = m_tdata[HALF_W+IDX_W-1:HALF_W];
                got.row_end = m_tlast;
                if (halfword_q.size() == 0) begin
                    note_mismatch($sformatf("halfword %h index %0d with nothing expected",
                                            got.bits, got.index));
                end else begin
                    want = halfword_q.pop_front();
                    if (got.bits !== want.bits)
                        note_mismatch($sformatf("out_bits %h, expected %h at index %0d",
                                                got.bits, want.bits, want.index));
                    if (got.index !== want.index)
                        note_mismatch($sformatf("halfword_index %0d, expected %0d",
                                                got.index, want.index));
                    if (got.row_end !== want.row_end)
                        note_mismatch($sformatf("row_end %b, expected %b at index %0d",
                                                got.row_end, want.row_end, want.index));
                end
            end

            if (s_tvalid && s_tready) begin
                word = s_tdata;
                if (s_tuser[0]) begin
                    col_pos    = 0;
                    on_odd_row = 1'b0;
                end
                wpr     = source_words(width_cfg);
                emit    = emitting_words(width_cfg);
                col_pos = col_pos % STORE_DEPTH;
                if (!on_odd_row) begin
                    even_row_words[col_pos] = word;
                end else if (col_pos < emit) begin
                    want.bits    = reduce_cells(even_row_words[col_pos], word, rank_cfg);
                    want.index   = col_pos[IDX_W-1:0];
                    want.row_end = (col_pos + 1 == emit);
                    halfword_q.push_back(want);
                end
                col_pos++;
                if (col_pos >= wpr) begin
                    col_pos    = 0;
                    on_odd_row = !on_odd_row;
                end
            end

            pending    <= halfword_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for binary_rank_reduce_2x_top: clock, reset, stimulus and verdict.
// Depends on brr2x_pkg, the block's RTL and brr2x_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brr2x_pkg::*;

    // rank codes beyond the package's set
    localparam logic [LEVEL_W-1:0] RANK_ALL = 3'd4;   // all four pixels on
    localparam logic [LEVEL_W-1:0] RANK_CAP = 3'd7;   // above four, acts as four

    localparam logic [WIDTH_W-1:0] WIDTH_NARROW    = 13'd1;   // no output columns
    localparam logic [WIDTH_W-1:0] WIDTH_TWO_WORDS = 13'd64;

    // top and bottom words that give all sixteen 2x2 cell patterns
    localparam logic [31:0] CELL_COMBO_TOP = 32'h0055_AAFF;
    localparam logic [31:0] CELL_COMBO_BOT = 32'h1B1B_1B1B;

    localparam logic [LEVEL_W-1:0] DIR_RANK [6] =
        '{RANK_SUBSAMPLE, RANK_ONE, RANK_TWO, RANK_THREE, RANK_ALL, RANK_CAP};
    localparam logic [31:0] DIR_TOP [6] =
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000};
    localparam logic [31:0] DIR_BOT [6] =
        '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000};
    // widths around word and pair boundaries, plus the far extreme
    localparam logic [WIDTH_W-1:0] EDGE_WIDTH [9] =
        '{13'd2, 13'd3, 13'd31, 13'd32, 13'd33, 13'd63, 13'd64, 13'd65, 13'h1FFF};

    localparam int WORD_TARGET = 800;
    localparam int HEAVY_PCT   = 86;
    localparam int LIGHT_PCT   = 11;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int pending;
    int fail_count;
    int gap_pct   = 0;
    int stall_pct = 0;
    int words_sent = 0;

    binary_rank_reduce_2x_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    brr2x_checker scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: redraw ready every cycle from the current stall rate
    initial begin
        forever begin
            @(posedge aclk);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one word, after a random gap, and hold it until the transaction
    // completes. Valid stays high into the next call when no gap is drawn.
    task automatic send_word(input logic [31:0] word, input bit frame_first);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= frame_first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid, wait out every expected halfword, then idle for tail more
    // clocks so the two-stage pipeline is clear.
    task automatic drain(input int tail);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // Write both registers on back-to-back edges; enable stays high between.
    task automatic set_config(input logic [LEVEL_W-1:0] rank, input logic [WIDTH_W-1:0] width);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_RANK_LEVEL;
        cfg_wdata <= CFG_DATA_W'(rank);
        @(posedge aclk);
        cfg_addr  <= REG_WIDTH_PIXELS;
        cfg_wdata <= CFG_DATA_W'(width);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin
                gap_pct   <= 0;
                stall_pct <= 0;
            end
            IDLE_SENDER: begin
                gap_pct   <= HEAVY_PCT;
                stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                gap_pct   <= 0;
                stall_pct <= HEAVY_PCT;
            end
            default: begin
                gap_pct   <= LIGHT_PCT;
                stall_pct <= LIGHT_PCT;
            end
        endcase
    endtask

    function automatic int source_words(input logic [WIDTH_W-1:0] w);
        int n;
        n = (w + 31) / 32;
        if (n < 1) n = 1;
        if (n > MAX_WORDS_DEFAULT) n = MAX_WORDS_DEFAULT;
        return n;
    endfunction

    // mostly narrow images so rows stay short; a few full and oversize ones
    function automatic logic [WIDTH_W-1:0] pick_width();
        case ($urandom_range(19))
            0:       return WIDTH_W'($urandom_range(0, 1));
            1:       return WIDTH_PIXELS_RESET;
            2:       return WIDTH_W'($urandom_range(4097, 8191));
            3, 4:    return WIDTH_W'($urandom_range(257, 1024));
            5, 6:    return EDGE_WIDTH[$urandom_range(8)];
            default: return WIDTH_W'($urandom_range(2, 256));
        endcase
    endfunction

    // bias toward solid and sparse/dense words so every rank sees all counts
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom & $urandom & $urandom;
            3:       return $urandom | $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Frames of 1..6 full rows (odd counts leave an unpaired row), each
    // opened by frame_start (the first only on restart); a few stray frame_start flags break rows.
    // Without restart the phase picks up the previous frame where it stopped.
    task automatic run_frames(input int budget, input bit restart, input logic [WIDTH_W-1:0] width);
        int wpr;
        int col;
        int rows_left;
        bit frame_first;
        wpr       = source_words(width);
        col       = 0;
        rows_left = 0;
        for (int n = 0; n < budget; n++) begin
            frame_first = 1'b0;
            if (col == 0 && rows_left == 0) begin
                rows_left   = $urandom_range(1, 6);
                frame_first = restart || (n > 0);
            end
            if ($urandom_range(99) < 3)
                frame_first = 1'b1;
            send_word(pick_word(), frame_first);
            words_sent++;
            col++;
            if (col >= wpr) begin
                col = 0;
                rows_left--;
            end
        end
    endtask

    initial begin
        idle_mode_e mode;
        int         phase;
        logic [WIDTH_W-1:0] width;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: one two-word row pair per rank code. Column 0 holds all
        // sixteen cell patterns, column 1 the solid and checkerboard cases.
        for (int p = 0; p < 6; p++) begin
            drain(4);
            set_idle(idle_mode_e'(p % 4));
            set_config(DIR_RANK[p], WIDTH_TWO_WORDS);
            send_word(CELL_COMBO_TOP, 1'b1);
            send_word(DIR_TOP[p], 1'b0);
            send_word(CELL_COMBO_BOT, 1'b0);
            send_word(DIR_BOT[p], 1'b0);
        end

        // narrow width: one word per row and no output columns at all
        drain(4);
        set_config(RANK_ONE, WIDTH_NARROW);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);

        // Full-width frame: the even row writes every line-store entry, so
        // later phases may widen mid-frame without reading stale-at-reset data.
        drain(4);
        set_idle(IDLE_NONE);
        set_config(LEVEL_W'($urandom_range(0, 7)), WIDTH_PIXELS_RESET);
        for (int n = 0; n < 2 * MAX_WORDS_DEFAULT; n++) begin
            send_word(pick_word(), n == 0);
            words_sent++;
        end

        // random phases, rotating through the idle modes
        phase = 0;
        while (words_sent < WORD_TARGET) begin
            drain(4);
            mode = idle_mode_e'(phase % 4);
            set_idle(mode);
            width = pick_width();
            set_config(LEVEL_W'($urandom_range(0, 7)), width);
            run_frames($urandom_range(20, 80), $urandom_range(3) != 0, width);
            phase++;
        end

        set_idle(IDLE_NONE);
        drain(8);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/brr2x_pkg.sv
hw/rtl/brr2x_lane.sv
hw/rtl/brr2x_line_store.sv
hw/rtl/binary_rank_reduce_2x_top.sv
hw/rtl/brr2x_checker.sv
tb/brr2x_checker.sv
tb/tb.sv
